@@ hdl/length_prefix_deframer_unit_assert.svh @@
// Assertion macros for the deframer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

@@ hdl/lpd_pkg.sv @@
// Package for the length-prefix deframer: result type and fixed constants.
// Depends on nothing; used by the interfaces and every RTL module.
`default_nettype none

package lpd_pkg;

    localparam int unsigned LPD_LEN_W      = 32;
    localparam int unsigned LPD_BYTE_W     = 8;
    localparam int unsigned LPD_MAX_HDR    = 4;
    localparam int unsigned LPD_HDR_CNT_W  = 2;
    localparam int unsigned LPD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [LPD_BYTE_W-1:0] out_byte;
        logic                  is_last;
        logic                  is_error;
        logic [LPD_LEN_W-1:0]  frame_length;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/lpd_if.sv @@
// Handshake interfaces for the deframer's byte input and result output.
// Depends on lpd_pkg.
`default_nettype none

interface lpd_byte_if
    import lpd_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [LPD_BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if
    import lpd_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [LPD_BYTE_W-1:0] out_byte;
    logic                  is_last;
    logic                  is_error;
    logic [LPD_LEN_W-1:0]  frame_length;

    modport source (output valid, output out_byte, output is_last, output is_error,
                    output frame_length, input ready);
    modport sink (input valid, input out_byte, input is_last, input is_error,
                  input frame_length, output ready);
endinterface

`default_nettype wire

@@ hdl/length_prefix_deframer_unit.sv @@
// Top level of the length-prefix deframer: front end, result queue, back end.
// Depends on lpd_pkg, lpd_if, lpd_front, lpd_queue and lpd_back.
//
//   Port    Direction  Carries
//   i_in    in         one stream byte per transaction (in_byte)
//   o_out   out        out_byte, is_last, is_error, frame_length
//
// One byte is accepted per cycle while the queue is not full; header bytes give no
// output, but a zero length gives an error result. Results pass through the queue
// and then the back end's output register before they are valid on o_out.
// Reset is synchronous; afterwards the block expects the first header byte.
// i_in.ready drops only while the queue is full under output back-pressure.
`default_nettype none

module length_prefix_deframer_unit
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lpd_byte_if.sink      i_in,
    lpd_result_if.source  o_out
);

    logic    push_valid;
    t_result push_data;
    logic    queue_full;
    logic    queue_empty;
    logic    pop;
    t_result pop_data;

    lpd_front #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_queue_full (queue_full)
    );

    lpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_empty     (queue_empty),
        .o_pop_data  (pop_data)
    );

    lpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (queue_empty),
        .i_pop_data (pop_data),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

@@ hdl/lpd_front.sv @@
// Front end of the deframer: accepts bytes, tracks header and payload state,
// and pushes result transactions into the queue. Depends on lpd_pkg, lpd_if and the assertion header.
`default_nettype none
`include "length_prefix_deframer_unit_assert.svh"

module lpd_front
    import lpd_pkg::*;
#(
    parameter int unsigned LENGTH_BYTES = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpd_byte_if.sink   i_in,
    output logic       o_push_valid,
    output t_result    o_push_data,
    input  wire logic  i_queue_full
);

    localparam logic [LPD_HDR_CNT_W-1:0] LastHdr = LPD_HDR_CNT_W'(LENGTH_BYTES - 1);

    logic [LPD_HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [LPD_LEN_W-1:0]     r_len_acc, n_len_acc;
    logic [LPD_LEN_W-1:0]     r_remaining, n_remaining;

    logic                 accept;
    logic                 hdr_mode;
    logic [LPD_LEN_W-1:0] acc_base;
    logic [LPD_LEN_W-1:0] acc_hdr;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && i_in.ready;
    assign hdr_mode   = (r_remaining == '0);

    always_comb begin
        acc_base = (r_hdr_cnt == '0) ? '0 : r_len_acc;
        for (int i = 0; i < LPD_MAX_HDR; i++) begin
            acc_hdr[LPD_BYTE_W*i +: LPD_BYTE_W] =
                (r_hdr_cnt == LPD_HDR_CNT_W'(i)) ? i_in.in_byte
                                                 : acc_base[LPD_BYTE_W*i +: LPD_BYTE_W];
        end
    end

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_len_acc    = r_len_acc;
        n_remaining  = r_remaining;
        o_push_valid = 1'b0;
        o_push_data  = '{out_byte: '0, is_last: 1'b0, is_error: 1'b1, frame_length: '0};
        if (accept) begin
            if (hdr_mode) begin
                n_len_acc = acc_hdr;
                if (r_hdr_cnt == LastHdr) begin
                    n_hdr_cnt = '0;
                    if (acc_hdr == '0) begin
                        o_push_valid = 1'b1;
                    end else begin
                        n_remaining = acc_hdr;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end
            end else begin
                o_push_valid = 1'b1;
                o_push_data  = '{out_byte: i_in.in_byte,
                                 is_last: (r_remaining == LPD_LEN_W'(1)),
                                 is_error: 1'b0,
                                 frame_length: r_len_acc};
                n_remaining  = r_remaining - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= '0;
            r_len_acc   <= '0;
            r_remaining <= '0;
        end else begin
            r_hdr_cnt   <= n_hdr_cnt;
            r_len_acc   <= n_len_acc;
            r_remaining <= n_remaining;
        end
    end

    `LPD_ASSERT_NEXT(a_frame_end_to_header, i_clk, i_rst_n, accept && (r_remaining == LPD_LEN_W'(1)), (r_remaining == '0) && (r_hdr_cnt == '0))
    `LPD_ASSERT_IMPL(a_no_header_in_payload, i_clk, i_rst_n, r_remaining != '0, r_hdr_cnt == '0)
    `LPD_ASSERT_IMPL(a_error_is_clean, i_clk, i_rst_n, o_push_valid && o_push_data.is_error, (o_push_data.frame_length == '0) && !o_push_data.is_last && (r_remaining == '0))
    `LPD_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_queue_full, !o_push_valid)

endmodule

`default_nettype wire

@@ hdl/lpd_queue.sv @@
// Two-entry queue of result transactions between the front and back ends.
// Depends on lpd_pkg.
`default_nettype none

module lpd_queue
    import lpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_push_data,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_result       o_pop_data
);

    localparam int unsigned CntW = $clog2(LPD_QUEUE_DEPTH + 1);
    localparam int unsigned PtrW = $clog2(LPD_QUEUE_DEPTH);

    t_result             r_mem [LPD_QUEUE_DEPTH];
    logic [PtrW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]     r_count;
    logic                do_push, do_pop;

    assign o_full     = (r_count == CntW'(LPD_QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/lpd_back.sv @@
// Back end of the deframer: drains the queue into the registered output port.
// Depends on lpd_pkg, lpd_if.
`default_nettype none

module lpd_back
    import lpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_empty,
    input  wire t_result  i_pop_data,
    output logic          o_pop,
    lpd_result_if.source  o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_pop_data;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.is_last      = r_res.is_last;
    assign o_out.is_error     = r_res.is_error;
    assign o_out.frame_length = r_res.frame_length;

endmodule

`default_nettype wire
